[rtl/core/lcal_pkg.sv]
// Shared types, constants and helper functions for the binary-lifting
// lowest common ancestor core. No dependencies; used by every file of the core.
`default_nettype none

package lcal_pkg;

    // Field and storage widths.
    localparam int NODE_W = 10;
    localparam int LVL_W  = 4;
    localparam int ANC_W  = 11;
    localparam int DEP_W  = 10;
    localparam int CNT_W  = 11;
    localparam int ADDR_W = NODE_W + LVL_W;

    // Table geometry.
    localparam int NODES  = 1024;
    localparam int LEVELS = 10;

    // Ancestor code for "no node".
    localparam logic [ANC_W-1:0] NO_NODE = '1;

    // Result kinds.
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B_LEVEL,
        ST_B_NODE,
        ST_B_UP,
        ST_B_FILL,
        ST_Q_DU,
        ST_Q_DV,
        ST_Q_SWAP,
        ST_Q_L1,
        ST_Q_L1A,
        ST_Q_L1D,
        ST_Q_L1N,
        ST_Q_CMP,
        ST_Q_L2,
        ST_Q_L2E,
        ST_Q_FIN,
        ST_Q_ANS,
        ST_OUT
    } state_t;

    // Requests from the controller to the table and depth memories.
    typedef struct packed {
        logic              anc_we;
        logic [ADDR_W-1:0] anc_waddr;
        logic [ANC_W-1:0]  anc_wdata;
        logic              rda_en;
        logic [ADDR_W-1:0] rda_addr;
        logic              rdb_en;
        logic [ADDR_W-1:0] rdb_addr;
        logic              dep_we;
        logic [NODE_W-1:0] dep_waddr;
        logic [DEP_W-1:0]  dep_wdata;
        logic              dep_re;
        logic [NODE_W-1:0] dep_raddr;
    } mem_req_t;

    // Position of the highest set bit, zero for zero, capped at the top level.
    function automatic logic [LVL_W-1:0] floor_log(input logic [DEP_W-1:0] d);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int b = 0; b < DEP_W; b++) begin
            if (d[b]) begin
                k = LVL_W'(b);
            end
        end
        if (k > LVL_W'(LEVELS - 1)) begin
            k = LVL_W'(LEVELS - 1);
        end
        return k;
    endfunction

    // Table address of one node at one level.
    function automatic logic [ADDR_W-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LVL_W-1:0] lvl);
        return {node, lvl};
    endfunction

endpackage

`default_nettype wire

[rtl/core/lcal_store.sv]
// Ancestor table (one write port, two read ports) and depth store (one write,
// one read port), all reads registered. Depends on lcal_pkg.
`default_nettype none

module lcal_store (
    input  wire logic                            clk,
    input  wire lcal_pkg::mem_req_t              req,
    output logic        [lcal_pkg::ANC_W-1:0]    rd_a,
    output logic        [lcal_pkg::ANC_W-1:0]    rd_b,
    output logic        [lcal_pkg::DEP_W-1:0]    rd_dep
);

    localparam int ANC_DEPTH = 1 << lcal_pkg::ADDR_W;

    logic [lcal_pkg::ANC_W-1:0] anc_mem [ANC_DEPTH];
    logic [lcal_pkg::DEP_W-1:0] dep_mem [lcal_pkg::NODES];

    logic [lcal_pkg::ANC_W-1:0] rd_a_reg;
    logic [lcal_pkg::ANC_W-1:0] rd_b_reg;
    logic [lcal_pkg::DEP_W-1:0] rd_dep_reg;

    // Ancestor table: write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (req.anc_we)
        begin
            anc_mem[req.anc_waddr] <= req.anc_wdata;
        end
        if (req.rda_en)
        begin
            rd_a_reg <= anc_mem[req.rda_addr];
        end
        if (req.rdb_en)
        begin
            rd_b_reg <= anc_mem[req.rdb_addr];
        end
    end

    // Depth store: write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.dep_we)
        begin
            dep_mem[req.dep_waddr] <= req.dep_wdata;
        end
        if (req.dep_re)
        begin
            rd_dep_reg <= dep_mem[req.dep_raddr];
        end
    end

    assign rd_a   = rd_a_reg;
    assign rd_b   = rd_b_reg;
    assign rd_dep = rd_dep_reg;

endmodule

`default_nettype wire

[rtl/core/lowest_common_ancestor_lifting_core.sv]
// Top level of the binary-lifting lowest common ancestor core: controller,
// datapath registers and output register. Depends on lcal_pkg and lcal_store.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// in       | input     | in_valid / in_stall    | action, node_index, parent_index,
//          |           |                        | depth_value, second_node
// out      | output    | out_valid / out_stall  | ancestor, result_kind
// cfg      | input     | cfg_wen                | cfg_wdata (node_count)
//
// A load transaction leaves the core idle, so loads can follow back to back. A build
// walks the levels in turn; for each node it reads the node's entry at the level below,
// then that ancestor's entry at the level below, and writes the result; a node with no
// ancestor at the level below gets the no-node code written directly. A query reads both
// depths, makes u the deeper node and lifts u level by level; if u then differs from v,
// it climbs both nodes level by level before reading the parent of u.
// Reset returns the controller to idle, clears out_valid and sets node_count to 1; the memories are not cleared.
// A finished result waits in the output register under out_stall while the next
// transaction is taken; a further result waits in the core until that register frees.
`default_nettype none

module lowest_common_ancestor_lifting_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [lcal_pkg::CNT_W-1:0]      cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      action,
    input  wire logic [lcal_pkg::NODE_W-1:0]     node_index,
    input  wire logic [lcal_pkg::ANC_W-1:0]      parent_index,
    input  wire logic [lcal_pkg::DEP_W-1:0]      depth_value,
    input  wire logic [lcal_pkg::NODE_W-1:0]     second_node,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [lcal_pkg::ANC_W-1:0]      ancestor,
    output logic                                 result_kind
);

    localparam int NW = lcal_pkg::NODE_W;
    localparam int LW = lcal_pkg::LVL_W;
    localparam int AW = lcal_pkg::ANC_W;
    localparam int DW = lcal_pkg::DEP_W;
    localparam int CW = lcal_pkg::CNT_W;

    lcal_pkg::state_t   state_reg, state_next;
    lcal_pkg::mem_req_t req;

    logic [CW-1:0] node_count_reg, node_count_next;
    logic [AW-1:0] u_reg, u_next;
    logic [AW-1:0] v_reg, v_next;
    logic [DW-1:0] du_reg, du_next;
    logic [DW-1:0] dv_reg, dv_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [LW-1:0] blvl_reg, blvl_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] ans_reg, ans_next;
    logic          kind_reg, kind_next;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_anc_reg, out_anc_next;
    logic          out_kind_reg, out_kind_next;

    logic [AW-1:0] rd_a;
    logic [AW-1:0] rd_b;
    logic [DW-1:0] rd_dep;

    logic          in_accept;
    logic          out_free;
    logic [CW-1:0] n_eff;
    logic          level_go;
    logic          node_go;
    logic          lift_ok;
    logic [AW-1:0] au;
    logic [AW-1:0] av;
    logic          climb;

    lcal_store u_store (
        .clk    (clk),
        .req    (req),
        .rd_a   (rd_a),
        .rd_b   (rd_b),
        .rd_dep (rd_dep)
    );

    // Handshake and shared conditions.
    assign in_stall  = (state_reg != lcal_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign n_eff    = (node_count_reg > CW'(lcal_pkg::NODES)) ? CW'(lcal_pkg::NODES)
                                                              : node_count_reg;
    assign level_go = (blvl_reg < LW'(lcal_pkg::LEVELS)) &&
                      ((CW'(1) << blvl_reg) < n_eff);
    assign node_go  = (idx_reg < n_eff);
    assign lift_ok  = ({1'b0, du_reg} >= ({1'b0, dv_reg} + (CW'(1) << lvl_reg)));

    // Ancestors of the two climbing nodes; a missing node has no ancestor.
    assign au    = u_reg[AW-1] ? lcal_pkg::NO_NODE : rd_a;
    assign av    = v_reg[AW-1] ? lcal_pkg::NO_NODE : rd_b;
    assign climb = (au != lcal_pkg::NO_NODE) && (au != av);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcal_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (lcal_pkg::action_t'(action))
                        lcal_pkg::ACT_LOAD:  state_next = lcal_pkg::ST_IDLE;
                        lcal_pkg::ACT_BUILD: state_next = lcal_pkg::ST_B_LEVEL;
                        lcal_pkg::ACT_QUERY: state_next = lcal_pkg::ST_Q_DU;
                        lcal_pkg::ACT_NONE:  state_next = lcal_pkg::ST_IDLE;
                    endcase
                end
            end
            lcal_pkg::ST_B_LEVEL:
                state_next = level_go ? lcal_pkg::ST_B_NODE : lcal_pkg::ST_OUT;
            lcal_pkg::ST_B_NODE:
                state_next = node_go ? lcal_pkg::ST_B_UP : lcal_pkg::ST_B_LEVEL;
            lcal_pkg::ST_B_UP:
                state_next = (rd_a == lcal_pkg::NO_NODE) ? lcal_pkg::ST_B_NODE
                                                         : lcal_pkg::ST_B_FILL;
            lcal_pkg::ST_B_FILL: state_next = lcal_pkg::ST_B_NODE;
            lcal_pkg::ST_Q_DU:   state_next = lcal_pkg::ST_Q_DV;
            lcal_pkg::ST_Q_DV:   state_next = lcal_pkg::ST_Q_SWAP;
            lcal_pkg::ST_Q_SWAP: state_next = lcal_pkg::ST_Q_L1;
            lcal_pkg::ST_Q_L1:
                state_next = lift_ok ? lcal_pkg::ST_Q_L1A : lcal_pkg::ST_Q_L1N;
            lcal_pkg::ST_Q_L1A:
                state_next = rd_a[AW-1] ? lcal_pkg::ST_Q_L1N : lcal_pkg::ST_Q_L1D;
            lcal_pkg::ST_Q_L1D:  state_next = lcal_pkg::ST_Q_L1N;
            lcal_pkg::ST_Q_L1N:
                state_next = (lvl_reg == '0) ? lcal_pkg::ST_Q_CMP : lcal_pkg::ST_Q_L1;
            lcal_pkg::ST_Q_CMP:
                state_next = (u_reg == v_reg) ? lcal_pkg::ST_OUT : lcal_pkg::ST_Q_L2;
            lcal_pkg::ST_Q_L2:   state_next = lcal_pkg::ST_Q_L2E;
            lcal_pkg::ST_Q_L2E:
                state_next = (lvl_reg == '0) ? lcal_pkg::ST_Q_FIN : lcal_pkg::ST_Q_L2;
            lcal_pkg::ST_Q_FIN:  state_next = lcal_pkg::ST_Q_ANS;
            lcal_pkg::ST_Q_ANS:  state_next = lcal_pkg::ST_OUT;
            lcal_pkg::ST_OUT:
                state_next = out_free ? lcal_pkg::ST_IDLE : lcal_pkg::ST_OUT;
            default:             state_next = lcal_pkg::ST_IDLE;
        endcase
    end

    // Memory requests issued in each state.
    always_comb
    begin
        req = '0;
        unique case (state_reg)
            lcal_pkg::ST_IDLE:
            begin
                if (in_accept && (lcal_pkg::action_t'(action) == lcal_pkg::ACT_LOAD))
                begin
                    req.anc_we    = 1'b1;
                    req.anc_waddr = lcal_pkg::anc_addr(node_index, '0);
                    req.anc_wdata = parent_index[AW-1] ? lcal_pkg::NO_NODE : parent_index;
                    req.dep_we    = 1'b1;
                    req.dep_waddr = node_index;
                    req.dep_wdata = depth_value;
                end
            end
            lcal_pkg::ST_B_NODE:
            begin
                if (node_go)
                begin
                    req.rda_en   = 1'b1;
                    req.rda_addr = lcal_pkg::anc_addr(idx_reg[NW-1:0],
                                                      blvl_reg - LW'(1));
                end
            end
            lcal_pkg::ST_B_UP:
            begin
                if (rd_a == lcal_pkg::NO_NODE)
                begin
                    req.anc_we    = 1'b1;
                    req.anc_waddr = lcal_pkg::anc_addr(idx_reg[NW-1:0], blvl_reg);
                    req.anc_wdata = lcal_pkg::NO_NODE;
                end
                else
                begin
                    req.rda_en   = 1'b1;
                    req.rda_addr = lcal_pkg::anc_addr(rd_a[NW-1:0], blvl_reg - LW'(1));
                end
            end
            lcal_pkg::ST_B_FILL:
            begin
                req.anc_we    = 1'b1;
                req.anc_waddr = lcal_pkg::anc_addr(idx_reg[NW-1:0], blvl_reg);
                req.anc_wdata = rd_a;
            end
            lcal_pkg::ST_Q_DU:
            begin
                req.dep_re    = 1'b1;
                req.dep_raddr = u_reg[NW-1:0];
            end
            lcal_pkg::ST_Q_DV:
            begin
                req.dep_re    = 1'b1;
                req.dep_raddr = v_reg[NW-1:0];
            end
            lcal_pkg::ST_Q_L1:
            begin
                if (lift_ok)
                begin
                    req.rda_en   = 1'b1;
                    req.rda_addr = lcal_pkg::anc_addr(u_reg[NW-1:0], lvl_reg);
                end
            end
            lcal_pkg::ST_Q_L1A:
            begin
                if (!rd_a[AW-1])
                begin
                    req.dep_re    = 1'b1;
                    req.dep_raddr = rd_a[NW-1:0];
                end
            end
            lcal_pkg::ST_Q_L2:
            begin
                req.rda_en   = 1'b1;
                req.rda_addr = lcal_pkg::anc_addr(u_reg[NW-1:0], lvl_reg);
                req.rdb_en   = 1'b1;
                req.rdb_addr = lcal_pkg::anc_addr(v_reg[NW-1:0], lvl_reg);
            end
            lcal_pkg::ST_Q_FIN:
            begin
                req.rda_en   = 1'b1;
                req.rda_addr = lcal_pkg::anc_addr(u_reg[NW-1:0], '0);
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        du_next   = du_reg;
        dv_next   = dv_reg;
        lvl_next  = lvl_reg;
        blvl_next = blvl_reg;
        idx_next  = idx_reg;
        ans_next  = ans_reg;
        kind_next = kind_reg;
        unique case (state_reg)
            lcal_pkg::ST_IDLE:
            begin
                u_next    = {1'b0, node_index};
                v_next    = {1'b0, second_node};
                blvl_next = LW'(1);
            end
            lcal_pkg::ST_B_LEVEL:
            begin
                idx_next = '0;
                if (!level_go)
                begin
                    ans_next  = '0;
                    kind_next = lcal_pkg::KIND_BUILD;
                end
            end
            lcal_pkg::ST_B_NODE:
            begin
                if (!node_go)
                begin
                    blvl_next = blvl_reg + LW'(1);
                end
            end
            lcal_pkg::ST_B_UP:
            begin
                if (rd_a == lcal_pkg::NO_NODE)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            lcal_pkg::ST_B_FILL:
            begin
                idx_next = idx_reg + CW'(1);
            end
            lcal_pkg::ST_Q_DV:
            begin
                du_next = rd_dep;
            end
            lcal_pkg::ST_Q_SWAP:
            begin
                // Make u the deeper node.
                if (du_reg < rd_dep)
                begin
                    u_next   = v_reg;
                    v_next   = u_reg;
                    du_next  = rd_dep;
                    dv_next  = du_reg;
                    lvl_next = lcal_pkg::floor_log(rd_dep);
                end
                else
                begin
                    dv_next  = rd_dep;
                    lvl_next = lcal_pkg::floor_log(du_reg);
                end
            end
            lcal_pkg::ST_Q_L1A:
            begin
                u_next = rd_a;
                if (rd_a[AW-1])
                begin
                    du_next = '0;
                end
            end
            lcal_pkg::ST_Q_L1D:
            begin
                du_next = rd_dep;
            end
            lcal_pkg::ST_Q_L1N:
            begin
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            lcal_pkg::ST_Q_CMP:
            begin
                lvl_next  = lcal_pkg::floor_log(du_reg);
                ans_next  = u_reg;
                kind_next = lcal_pkg::KIND_QUERY;
            end
            lcal_pkg::ST_Q_L2E:
            begin
                // Climb both nodes while u has an ancestor at this level and it differs from v's.
                if (climb)
                begin
                    u_next = au;
                    v_next = av;
                end
                if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            lcal_pkg::ST_Q_ANS:
            begin
                ans_next  = u_reg[AW-1] ? lcal_pkg::NO_NODE : rd_a;
                kind_next = lcal_pkg::KIND_QUERY;
            end
            default:
            begin
                u_next = u_reg;
            end
        endcase
    end

    // Output register and configuration register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_anc_next    = out_anc_reg;
        out_kind_next   = out_kind_reg;
        node_count_next = node_count_reg;
        if ((state_reg == lcal_pkg::ST_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_anc_next   = ans_reg;
            out_kind_next  = kind_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_wen)
        begin
            node_count_next = cfg_wdata;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcal_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            node_count_reg <= CW'(1);
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            node_count_reg <= node_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        du_reg       <= du_next;
        dv_reg       <= dv_next;
        lvl_reg      <= lvl_next;
        blvl_reg     <= blvl_next;
        idx_reg      <= idx_next;
        ans_reg      <= ans_next;
        kind_reg     <= kind_next;
        out_anc_reg  <= out_anc_next;
        out_kind_reg <= out_kind_next;
    end

    assign out_valid   = out_valid_reg;
    assign ancestor    = out_anc_reg;
    assign result_kind = out_kind_reg;

endmodule

`default_nettype wire

[rtl/core/lcal_checker.sv]
// Port-level checker for the lowest common ancestor core, bound to its top level.
// Depends on lcal_pkg and lowest_common_ancestor_lifting_core.
`default_nettype none

module lcal_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic [1:0]                  action,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [lcal_pkg::ANC_W-1:0]  ancestor,
    input wire logic                        result_kind
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ancestor) && $stable(result_kind))
        else $error("result payload changed while stalled");

    // A build result carries a zero ancestor.
    a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == lcal_pkg::KIND_BUILD) |-> (ancestor == '0))
        else $error("build result with nonzero ancestor");

    // A build or query transaction keeps the input side busy in the next cycle.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        ((action == lcal_pkg::ACT_BUILD) || (action == lcal_pkg::ACT_QUERY))
        |=> in_stall)
        else $error("input taken while a build or query is in progress");

endmodule

bind lowest_common_ancestor_lifting_core lcal_checker u_lcal_checker (.*);

`default_nettype wire
